[src/assert_macros.svh]
// assertion macros shared by the resampler rtl
// depends on nothing; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// when a holds, b holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// when a holds, b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[src/pfsr_pkg.sv]
// types, codes and rounding helpers for the pcm fifo speed resampler
// used by the top, the config registers and the controller; depends on nothing
package pfsr_pkg;

  localparam int unsigned SPEED_MAX = 40960;
  localparam int unsigned UNITY_VOL = 32768;
  localparam int unsigned FRAC_BITS = 12;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_PULL  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_CHANNELS = 2'd0,
    REG_SPEED    = 2'd1,
    REG_VOLUME   = 2'd2,
    REG_LIMIT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  channel_count;
    logic [15:0] speed_q12;
    logic [15:0] volume_q15;
    logic [12:0] queue_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_CHK, ST_EMUL, ST_END,
    ST_RD0, ST_RD1, ST_INT, ST_VOL, ST_SAT, ST_OUT
  } state_t;

  // round half away from zero, divide by 2^12
  function automatic logic signed [16:0] round12(input logic signed [30:0] x);
    logic [30:0] mag;
    logic [30:0] q;
    logic [16:0] r;
    mag = x[30] ? 31'(-x) : 31'(x);
    q   = (mag + 31'd2048) >> 12;
    r   = q[16:0];
    return x[30] ? -$signed(r) : $signed(r);
  endfunction

  // round half away from zero, divide by 2^15
  function automatic logic signed [17:0] round15(input logic signed [33:0] x);
    logic [33:0] mag;
    logic [33:0] q;
    logic [17:0] r;
    mag = x[33] ? 34'(-x) : 34'(x);
    q   = (mag + 34'd16384) >> 15;
    r   = q[17:0];
    return x[33] ? -$signed(r) : $signed(r);
  endfunction

endpackage

[src/pfsr_item_if.sv]
// input item channel: push, pull or clear
// depends on nothing
interface pfsr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] sample_in;
  logic        block_end;
  modport source (output valid, func, sample_in, block_end, input ready);
  modport sink (input valid, func, sample_in, block_end, output ready);
endinterface

[src/pfsr_result_if.sv]
// result channel: one beat per channel of a pulled frame, or one per push or clear
// depends on nothing
interface pfsr_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_out;
  logic [2:0]  channel_index;
  logic        last_of_frame;
  logic        accepted;
  logic [12:0] queued_samples;
  modport source (output valid, sample_out, channel_index, last_of_frame, accepted,
                  queued_samples, input ready);
  modport sink (input valid, sample_out, channel_index, last_of_frame, accepted,
                queued_samples, output ready);
endinterface

[src/pfsr_cfg_if.sv]
// configuration write channel
// depends on nothing
interface pfsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/pcm_fifo_speed_resampler_top.sv]
// Sample fifo with a linear-interpolation speed changer on its read side.
// A push or clear goes from the accepting idle state straight to one result
// beat, held until the result channel takes it. A pull passes through the
// position multiply and the fill check, then gives channel_count beats; each
// channel with real data fetches the two source samples one after the other
// through the single read port of the sample store, then does one
// interpolation multiply, one volume multiply and saturation, while a silent
// channel goes straight to saturation. A pull that ends a block adds the
// discard multiply before its first channel. Items are taken one at a time.
// No clearing pass is needed.
// depends on pfsr_pkg, the channel interfaces, assert_macros.svh and the cfg_regs, sample_mem and ctrl modules
`include "assert_macros.svh"
module pcm_fifo_speed_resampler_top
  import pfsr_pkg::*;
#(
  parameter int FIFO_DEPTH       = 4096,
  parameter int MAX_CHANNELS     = 8,
  parameter int MAX_BLOCK_FRAMES = 4096
) (
  input  logic          clk,
  input  logic          rst,
  pfsr_item_if.sink     items,
  pfsr_result_if.source results,
  pfsr_cfg_if.sink      cfg
);

  localparam int AW = $clog2(FIFO_DEPTH);

  cfg_t          regs;
  logic          wen, ren;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;

  pfsr_cfg_regs #(.MAX_CHANNELS(MAX_CHANNELS)) u_cfg (
    .clk(clk), .rst(rst), .cfg(cfg), .regs(regs)
  );

  pfsr_sample_mem #(.DEPTH(FIFO_DEPTH), .AW(AW)) u_mem (
    .clk(clk), .wen(wen), .waddr(waddr), .wdata(wdata),
    .ren(ren), .raddr(raddr), .rdata(rdata)
  );

  pfsr_ctrl #(
    .FIFO_DEPTH(FIFO_DEPTH), .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES), .AW(AW)
  ) u_ctrl (
    .clk(clk), .rst(rst), .regs(regs), .items(items), .results(results),
    .wen(wen), .waddr(waddr), .wdata(wdata), .ren(ren), .raddr(raddr), .rdata(rdata)
  );

  `ASSERT_IMPLIES(a_no_overlap, clk, rst, results.valid, !items.ready)
  `ASSERT_IMPLIES(a_ch_range, clk, rst, results.valid, 4'(results.channel_index) < regs.channel_count)
  `ASSERT_IMPLIES(a_vol_range, clk, rst, 1'b1, regs.volume_q15 <= 16'(UNITY_VOL))
  `ASSERT_NEXT(a_write_then_busy, clk, rst, wen, results.valid)

endmodule

[src/pfsr_cfg_regs.sv]
// configuration registers with write-time clamping; out-of-range speed writes are ignored
// depends on pfsr_pkg and pfsr_cfg_if
module pfsr_cfg_regs
  import pfsr_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst,
  pfsr_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.channel_count <= 4'd2;
      regs.speed_q12     <= 16'd4096;
      regs.volume_q15    <= 16'(UNITY_VOL);
      regs.queue_limit   <= '0;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_CHANNELS: begin
          if (cfg.data[3:0] == 4'd0) regs.channel_count <= 4'd2;
          else if (cfg.data[3:0] > 4'(MAX_CHANNELS)) regs.channel_count <= 4'(MAX_CHANNELS);
          else regs.channel_count <= cfg.data[3:0];
        end
        REG_SPEED: begin
          if (cfg.data != 16'd0 && 17'(cfg.data) <= 17'(SPEED_MAX))
            regs.speed_q12 <= cfg.data;
        end
        REG_VOLUME: begin
          regs.volume_q15 <= (cfg.data > 16'(UNITY_VOL)) ? 16'(UNITY_VOL) : cfg.data;
        end
        REG_LIMIT: regs.queue_limit <= cfg.data[12:0];
        default: ;
      endcase
    end
  end

endmodule

[src/pfsr_sample_mem.sv]
// sample store: one write port, one read port with registered data
// depends on nothing
module pfsr_sample_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wen,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          ren,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (ren) rdata <= mem[raddr];
  end

endmodule

[src/pfsr_ctrl.sv]
// sequencer and datapath: push/clear bookkeeping, per-channel interpolation,
// volume and block-end discard; depends on pfsr_pkg and the channel interfaces
module pfsr_ctrl
  import pfsr_pkg::*;
#(
  parameter int FIFO_DEPTH       = 4096,
  parameter int MAX_BLOCK_FRAMES = 4096,
  parameter int AW               = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          regs,
  pfsr_item_if.sink     items,
  pfsr_result_if.source results,
  output logic          wen,
  output logic [AW-1:0] waddr,
  output logic [15:0]   wdata,
  output logic          ren,
  output logic [AW-1:0] raddr,
  input  logic [15:0]   rdata
);

  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int IW  = (MAX_BLOCK_FRAMES > 1) ? $clog2(MAX_BLOCK_FRAMES) : 1;
  localparam int FPW = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int PW  = IW + 16;
  localparam int QW  = FPW + 16;
  localparam int OW  = ((PW - 12 + 5) > CW ? (PW - 12 + 5) : CW) + 1;
  localparam int SW  = (OW > AW ? OW : AW) + 1;

  state_t state, state_next;

  logic [AW-1:0]  head, base;
  logic [CW-1:0]  fill;
  logic [IW-1:0]  bidx;
  logic [FPW-1:0] fprod;
  logic           stalled, ends, is_pull, real_data, has1;
  logic [2:0]     ch;
  logic [PW-1:0]  p;
  logic [QW-1:0]  q;
  logic [OW-1:0]  off0;
  logic [11:0]    frac;
  logic signed [15:0] s0;
  logic signed [30:0] acc;
  logic signed [16:0] vreg;
  logic signed [33:0] vprod;

  logic [15:0] o_sample;
  logic [2:0]  o_ch;
  logic        o_last, o_acc;
  logic [12:0] o_queued;

  logic [3:0]    nch;
  logic          push_ok;
  logic [OW-1:0] off0_c, off1_c, off2_c, rd_off, n_c, n_min;
  logic          ok_c, has1_c;
  logic [SW-1:0] rsum, wsum, hsum;
  logic signed [16:0] s1_c;
  logic signed [17:0] vfin;
  logic [15:0]   vsat;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(FIFO_DEPTH)) ? s - SW'(FIFO_DEPTH) : s;
    return r[AW-1:0];
  endfunction

  assign nch = regs.channel_count;

  always_comb begin
    push_ok = (fill < CW'(FIFO_DEPTH));
    if (regs.queue_limit != '0 && 14'(fill) + 14'd1 > 14'(regs.queue_limit)) push_ok = 1'b0;
    off0_c = OW'(p[PW-1:12]) * OW'(nch);
    off1_c = off0_c + OW'(nch);
    off2_c = off1_c + OW'(nch);
    ok_c   = !stalled && off1_c <= OW'(fill);
    has1_c = (p[11:0] != 12'd0) && off2_c <= OW'(fill);
    rd_off = off0 + OW'(ch) + ((state == ST_RD1) ? OW'(nch) : '0);
    rsum   = SW'(base) + SW'(rd_off);
    wsum   = SW'(head) + SW'(fill);
    n_c    = (OW'(q[QW-1:12]) + OW'(1) + OW'(q[11:0] != 12'd0)) * OW'(nch);
    n_min  = (fprod == '0) ? '0 : ((n_c > OW'(fill)) ? OW'(fill) : n_c);
    hsum   = SW'(head) + SW'(n_min);
    s1_c   = has1 ? 17'($signed(rdata)) : 17'(s0);
    vfin   = (regs.volume_q15 < 16'(UNITY_VOL)) ? round15(vprod) : 18'(vreg);
    if (vfin > 18'sd32767) vsat = 16'h7fff;
    else if (vfin < -18'sd32768) vsat = 16'h8000;
    else vsat = vfin[15:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (items.valid) begin
          case (func_t'(items.func))
            FUNC_PUSH, FUNC_CLEAR: state_next = ST_OUT;
            FUNC_PULL:             state_next = ST_MUL;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  state_next = ST_CHK;
      ST_CHK:  state_next = ends ? ST_EMUL : (ok_c ? ST_RD0 : ST_SAT);
      ST_EMUL: state_next = ST_END;
      ST_END:  state_next = real_data ? ST_RD0 : ST_SAT;
      ST_RD0:  state_next = ST_RD1;
      ST_RD1:  state_next = ST_INT;
      ST_INT:  state_next = ST_VOL;
      ST_VOL:  state_next = ST_SAT;
      ST_SAT:  state_next = ST_OUT;
      ST_OUT: begin
        if (results.ready) begin
          if (is_pull && !o_last) state_next = real_data ? ST_RD0 : ST_SAT;
          else state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    items.ready   = (state == ST_IDLE);
    results.valid = (state == ST_OUT);
    ren           = (state == ST_RD0) || (state == ST_RD1);
    raddr         = wrap(rsum);
    wen           = (state == ST_IDLE) && items.valid &&
                    (func_t'(items.func) == FUNC_PUSH) && push_ok;
    waddr         = wrap(wsum);
    wdata         = items.sample_in;
  end

  assign results.sample_out     = o_sample;
  assign results.channel_index  = o_ch;
  assign results.last_of_frame  = o_last;
  assign results.accepted       = o_acc;
  assign results.queued_samples = o_queued;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      fill    <= '0;
      bidx    <= '0;
      fprod   <= '0;
      stalled <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (items.valid) begin
            if (func_t'(items.func) == FUNC_PUSH && push_ok) fill <= fill + CW'(1);
            if (func_t'(items.func) == FUNC_CLEAR) begin
              head    <= '0;
              fill    <= '0;
              bidx    <= '0;
              fprod   <= '0;
              stalled <= 1'b0;
            end
          end
        end
        ST_CHK: begin
          if (ok_c) fprod <= fprod + FPW'(1);
          else stalled <= 1'b1;
          bidx <= bidx + IW'(1);
        end
        ST_END: begin
          head    <= wrap(hsum);
          fill    <= fill - CW'(n_min);
          bidx    <= '0;
          fprod   <= '0;
          stalled <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        base     <= head;
        ch       <= '0;
        ends     <= items.block_end || (32'(bidx) + 32'd1 >= 32'(MAX_BLOCK_FRAMES));
        is_pull  <= (func_t'(items.func) == FUNC_PULL);
        o_sample <= '0;
        o_ch     <= '0;
        o_last   <= 1'b1;
        o_acc    <= (func_t'(items.func) == FUNC_CLEAR) ? 1'b1 : push_ok;
        o_queued <= (func_t'(items.func) == FUNC_CLEAR) ? '0 :
                    13'(fill + CW'(push_ok));
        p        <= PW'(bidx) * PW'(regs.speed_q12);
      end
      ST_CHK: begin
        real_data <= ok_c;
        has1      <= has1_c;
        off0      <= off0_c;
        frac      <= p[11:0];
      end
      ST_EMUL: q <= QW'(fprod - FPW'(1)) * QW'(regs.speed_q12);
      ST_RD1:  s0 <= $signed(rdata);
      ST_INT:  acc <= (31'(s0) <<< 12) + 31'((s1_c - 17'(s0)) * $signed({1'b0, frac}));
      ST_VOL: begin
        vreg  <= round12(acc);
        vprod <= 34'(round12(acc)) * $signed({1'b0, regs.volume_q15});
      end
      ST_SAT: begin
        o_sample <= real_data ? vsat : '0;
        o_ch     <= ch;
        o_last   <= (4'(ch) + 4'd1 == nch);
        o_acc    <= real_data;
        o_queued <= 13'(fill);
      end
      ST_OUT: if (results.ready) ch <= ch + 3'd1;
      default: ;
    endcase
  end

endmodule

[tb/tb_pcm_fifo_speed_resampler_top.sv]
// self-checking testbench for pcm_fifo_speed_resampler_top: a scoreboard class predicts
// every result beat and compares it; depends on the dut, pfsr_pkg and the channel interfaces
module tb_pcm_fifo_speed_resampler_top;
  import pfsr_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int BLOCK_MAX   = 4096;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 80;

  typedef struct {
    logic [15:0] sample;
    logic [2:0]  chan;
    logic        last;
    logic        acc;
    logic [12:0] queued;
  } beat_t;

  class resampler_scoreboard;
    logic [15:0] store [DEPTH];
    int    head, fill, frame_idx, produced;
    bit    stalled;
    int    nch, speed, vol, qlimit;
    beat_t expected_q[$];
    int    errors;

    function new();
      head = 0; fill = 0; frame_idx = 0; produced = 0; stalled = 0;
      nch = 2; speed = 4096; vol = 32768; qlimit = 0; errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] d);
      int v;
      case (idx)
        REG_CHANNELS: begin
          v = d[3:0];
          if (v == 0) v = 2;
          if (v > 8) v = 8;
          nch = v;
        end
        REG_SPEED: begin
          if (d != 0 && d <= SPEED_MAX) speed = d;
        end
        REG_VOLUME: vol = (d > UNITY_VOL) ? UNITY_VOL : d;
        default: qlimit = d[12:0];
      endcase
    endfunction

    // divide by 2^k, halves away from zero
    function longint rnd_shift(longint x, int k);
      longint mag, q;
      mag = (x < 0) ? -x : x;
      q = (mag + (longint'(1) << (k - 1))) >>> k;
      return (x < 0) ? -q : q;
    endfunction

    function longint rd(longint off);
      return longint'($signed(store[(head + off) % DEPTH]));
    endfunction

    function void add_beat(logic [15:0] s, int ch, bit last, bit acc);
      beat_t b;
      b.sample = s; b.chan = ch[2:0]; b.last = last; b.acc = acc; b.queued = fill[12:0];
      expected_q.push_back(b);
    endfunction

    function void close_block();
      longint q, frames, n;
      if (produced > 0) begin
        q = longint'(produced - 1) * speed;
        frames = (q >>> 12) + 1 + (((q & 'hfff) != 0) ? 1 : 0);
        n = frames * nch;
        if (n > fill) n = fill;
        head = int'((head + n) % DEPTH);
        fill = int'(fill - n);
      end
      frame_idx = 0; produced = 0; stalled = 0;
    endfunction

    function void note_item(func_t f, logic [15:0] s, logic be);
      bit ok, got_data, has1, ends;
      longint p, f0, frac, s0, s1, v;
      logic [15:0] vals [8];
      case (f)
        FUNC_PUSH: begin
          ok = fill < DEPTH;
          if (qlimit > 0 && fill + 1 > qlimit) ok = 0;
          if (ok) begin
            store[(head + fill) % DEPTH] = s;
            fill++;
          end
          add_beat(16'd0, 0, 1, ok);
        end
        FUNC_CLEAR: begin
          head = 0; fill = 0; frame_idx = 0; produced = 0; stalled = 0;
          add_beat(16'd0, 0, 1, 1);
        end
        FUNC_PULL: begin
          got_data = 0;
          ends = be || (frame_idx + 1 >= BLOCK_MAX);
          for (int c = 0; c < 8; c++) vals[c] = 16'd0;
          if (!stalled) begin
            p = longint'(frame_idx) * speed;
            f0 = p >>> 12;
            frac = p & 'hfff;
            if ((f0 + 1) * nch <= fill) begin
              has1 = frac != 0 && (f0 + 2) * nch <= fill;
              got_data = 1;
              for (int c = 0; c < nch; c++) begin
                s0 = rd(f0 * nch + c);
                s1 = has1 ? rd((f0 + 1) * nch + c) : s0;
                v = rnd_shift(s0 * 4096 + (s1 - s0) * frac, 12);
                if (vol < UNITY_VOL) v = rnd_shift(v * vol, 15);
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                vals[c] = v[15:0];
              end
              produced++;
            end else begin
              stalled = 1;
            end
          end
          frame_idx++;
          if (ends) close_block();
          for (int c = 0; c < nch; c++) add_beat(vals[c], c, c + 1 == nch, got_data);
        end
        default: ;
      endcase
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_beat(beat_t got);
      beat_t e;
      if (expected_q.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (got.sample !== e.sample)
          report("sample_out", int'($signed(got.sample)), int'($signed(e.sample)));
        if (got.chan !== e.chan) report("channel_index", int'(got.chan), int'(e.chan));
        if (got.last !== e.last) report("last_of_frame", int'(got.last), int'(e.last));
        if (got.acc !== e.acc) report("accepted", int'(got.acc), int'(e.acc));
        if (got.queued !== e.queued)
          report("queued_samples", int'(got.queued), int'(e.queued));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  pfsr_item_if   items_if ();
  pfsr_result_if results_if ();
  pfsr_cfg_if    cfg_if ();

  pcm_fifo_speed_resampler_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if.sink),
    .results (results_if.source),
    .cfg     (cfg_if.sink)
  );

  resampler_scoreboard sb;
  int cycles;
  int src_idle;
  int dst_idle;
  int holdoff_req;
  int holdoff_left;

  initial begin
    clk = 0;
    rst = 1;
    items_if.valid = 0;
    items_if.func = FUNC_NONE;
    items_if.sample_in = 0;
    items_if.block_end = 0;
    results_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.index = REG_CHANNELS;
    cfg_if.data = 0;
    cycles = 0;
    src_idle = 0;
    dst_idle = 0;
    holdoff_req = 0;
    holdoff_left = 0;
    sb = new();
  end

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pcm_fifo_speed_resampler_top regression: fail");
      $finish;
    end
  end

  // result side: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (holdoff_req > 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (rst) begin
      results_if.ready <= 0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      results_if.ready <= 0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    beat_t got;
    if (!rst && results_if.valid && results_if.ready) begin
      got.sample = results_if.sample_out;
      got.chan = results_if.channel_index;
      got.last = results_if.last_of_frame;
      got.acc = results_if.accepted;
      got.queued = results_if.queued_samples;
      sb.check_beat(got);
    end
  end

  task send_item(func_t f, logic [15:0] s, logic be);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle) gap++;
    if (gap > 0) begin
      items_if.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid <= 1;
    items_if.func <= f;
    items_if.sample_in <= s;
    items_if.block_end <= be;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    sb.note_item(f, s, be);
  endtask

  task drain();
    items_if.valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    // an ignored item may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, logic [15:0] d);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, d);
    cfg_if.valid <= 0;
    @(posedge clk);
  endtask

  function logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // mostly pushes and pulls in blocks, now and then a clear or an unused code
  task random_item();
    int r, push_odds;
    r = $urandom_range(99);
    push_odds = (sb.fill < sb.nch * 4) ? 80 : 45;
    if (r < push_odds)
      send_item(FUNC_PUSH, pick_sample(), 1'($urandom_range(1)));
    else if (r < 96)
      send_item(FUNC_PULL, 16'($urandom_range(65535)), $urandom_range(3) == 0);
    else if (r < 98)
      send_item(FUNC_CLEAR, 16'($urandom_range(65535)), 1'($urandom_range(1)));
    else
      send_item(FUNC_NONE, 16'($urandom_range(65535)), 1'($urandom_range(1)));
  endtask

  logic [15:0] ch_set  [6] = '{16'd1, 16'd8, 16'd2, 16'd0, 16'd15, 16'd3};
  logic [15:0] spd_set [6] = '{16'd4096, 16'd40960, 16'd1, 16'd6144, 16'd0, 16'd3000};
  logic [15:0] vol_set [6] = '{16'd32768, 16'd0, 16'd16384, 16'd65535, 16'd20000, 16'd32767};
  logic [15:0] lim_set [6] = '{16'd0, 16'd4096, 16'd8, 16'd0, 16'd17, 16'd8191};

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: refusal by limit, underrun, discard, clear, unused code
    write_reg(REG_LIMIT, 16'd3);
    send_item(FUNC_PULL, 16'h0, 1'b0);
    send_item(FUNC_PULL, 16'h0, 1'b1);
    send_item(FUNC_PUSH, 16'h8000, 1'b0);
    send_item(FUNC_PUSH, 16'h7fff, 1'b1);
    send_item(FUNC_PUSH, 16'hffff, 1'b0);
    send_item(FUNC_PUSH, 16'h0001, 1'b0);
    send_item(FUNC_PULL, 16'hffff, 1'b0);
    send_item(FUNC_PULL, 16'h0, 1'b0);
    send_item(FUNC_PULL, 16'h0, 1'b1);
    send_item(FUNC_NONE, 16'h1234, 1'b1);
    drain();
    write_reg(REG_LIMIT, 16'd0);
    write_reg(REG_SPEED, 16'd6144);
    write_reg(REG_VOLUME, 16'd12345);
    for (int i = 0; i < 8; i++) send_item(FUNC_PUSH, (i & 1) ? 16'h7fff : 16'h8000, 1'b0);
    send_item(FUNC_PULL, 16'h0, 1'b0);
    send_item(FUNC_PULL, 16'h0, 1'b0);
    send_item(FUNC_PULL, 16'h0, 1'b1);
    send_item(FUNC_CLEAR, 16'h0, 1'b0);
    send_item(FUNC_PULL, 16'h0, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      src_idle = (ph < 2) ? 35 : (ph < 4) ? 65 : 0;
      dst_idle = (ph < 2) ? 65 : (ph < 4) ? 35 : 0;
      write_reg(REG_CHANNELS, ch_set[ph]);
      write_reg(REG_SPEED, spd_set[ph]);
      write_reg(REG_VOLUME, vol_set[ph]);
      write_reg(REG_LIMIT, lim_set[ph]);
      if (ph == 5) begin
        write_reg(reg_idx_t'(2'($urandom_range(3))), 16'($urandom_range(65535)));
        write_reg(REG_CHANNELS, 16'd8);
      end
      if (ph == 2) begin
        // long receiver hold-off while items keep coming
        holdoff_req = 400;
        for (int i = 0; i < 30; i++) random_item();
        drain();
      end
      for (int i = 0; i < 43; i++) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("pcm_fifo_speed_resampler_top regression: pass");
    end else begin
      $display("pcm_fifo_speed_resampler_top regression: fail");
    end
    $finish;
  end

endmodule
